// ===== sv/mfdr_pkg.sv =====
// Package for the mesh frame duplicate filter and relay block.
// Holds header constants, codes, controller states and command/status structs.
// No dependencies.
package mfdr_pkg;

  localparam int DEDUP_ENTRIES_DEF = 16;
  localparam int TEXT_MAX_DEF      = 16;

  localparam logic [7:0]  HDR_BYTES     = 8'd10;
  localparam logic [7:0]  HDR_MAGIC     = 8'hC3;
  localparam logic [7:0]  HDR_VERSION   = 8'd1;
  localparam logic [7:0]  HDR_TYPE_TEXT = 8'd1;
  localparam logic [31:0] WINDOW_RESET  = 32'd30000;
  localparam logic [15:0] ID_RESET      = 16'd1;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 40;
  localparam int RAM_W      = 64;

  typedef enum logic {
    CFG_NODE_ID = 1'b0,
    CFG_WINDOW  = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    V_ACCEPTED  = 3'd0,
    V_SHORT     = 3'd1,
    V_BAD_HDR   = 3'd2,
    V_BAD_TEXT  = 3'd3,
    V_TRUNCATED = 3'd4,
    V_DUPLICATE = 3'd5,
    V_LOCAL_OK  = 3'd6,
    V_LOCAL_REJ = 3'd7
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_WRITE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;      // capture the input transfer
    logic eval;      // run the header checks, set up the lookup key
    logic scan;      // walk the duplicate table
    logic write;     // record the key at the replacement cursor
    logic out_load;  // move the result into the output register
  } mfdr_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic hit;
  } mfdr_sts_t;

endpackage

// ===== sv/mfdr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/mfdr_ctrl.sv =====
// Controller state machine for the duplicate filter and relay block.
// Depends on mfdr_pkg; drives the datapath through mfdr_cmd_t.
module mfdr_ctrl import mfdr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  mfdr_sts_t sts,
  output mfdr_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.need_scan ? ST_SCAN : ST_RESULT;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = sts.hit ? ST_RESULT : ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        // The previous result must have gone before this one overwrites it.
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== sv/mfdr_dp.sv =====
// Datapath: input capture, header checks, duplicate table walk and result register.
// Depends on mfdr_pkg and mfdr_ram; controlled by mfdr_ctrl.
module mfdr_dp import mfdr_pkg::*; #(
  parameter int DEDUP_ENTRIES = DEDUP_ENTRIES_DEF,
  parameter int TEXT_MAX      = TEXT_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mfdr_cmd_t             cmd,
  output mfdr_sts_t             sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [31:0]           cfg_wdata,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [2:0]            out_tuser
);

  localparam int IW = (DEDUP_ENTRIES > 1) ? $clog2(DEDUP_ENTRIES) : 1;
  localparam int CW = $clog2(DEDUP_ENTRIES + 1);

  // Configuration registers.
  logic [31:0] node_id_r, window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r <= '0;
      window_r  <= WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_ID: node_id_r <= cfg_wdata;
        CFG_WINDOW:  window_r  <= cfg_wdata;
        default:     node_id_r <= node_id_r;
      endcase
    end
  end

  // Captured input item.
  logic        mode_r;
  logic [7:0]  flen_r, magic_r, ver_r, type_r, ttl_r, hops_r, tlen_r;
  logic [15:0] org_r, mid_r;
  logic [31:0] now_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_tuser;
      flen_r  <= in_tdata[7:0];
      magic_r <= in_tdata[15:8];
      ver_r   <= in_tdata[23:16];
      type_r  <= in_tdata[31:24];
      org_r   <= in_tdata[47:32];
      mid_r   <= in_tdata[63:48];
      ttl_r   <= in_tdata[71:64];
      hops_r  <= in_tdata[79:72];
      tlen_r  <= in_tdata[87:80];
      now_r   <= in_tdata[119:88];
    end
  end

  // Header and request checks, in priority order.
  logic     text_bad, truncated;
  logic     local_ok;
  verdict_t pre_verdict;
  logic [15:0] short_id;

  assign text_bad  = (tlen_r == 8'd0) || (tlen_r > 8'(TEXT_MAX));
  assign truncated = {1'b0, flen_r} < ({1'b0, HDR_BYTES} + {1'b0, tlen_r});
  assign local_ok  = (ttl_r != 8'd0) && !text_bad;
  assign short_id  = ((node_id_r[31:16] ^ node_id_r[15:0]) == 16'd0) ?
                     16'd1 : (node_id_r[31:16] ^ node_id_r[15:0]);

  always_comb begin
    if (mode_r) begin
      pre_verdict = local_ok ? V_LOCAL_OK : V_LOCAL_REJ;
    end else if (flen_r < HDR_BYTES) begin
      pre_verdict = V_SHORT;
    end else if (magic_r != HDR_MAGIC || ver_r != HDR_VERSION || type_r != HDR_TYPE_TEXT) begin
      pre_verdict = V_BAD_HDR;
    end else if (text_bad) begin
      pre_verdict = V_BAD_TEXT;
    end else if (truncated) begin
      pre_verdict = V_TRUNCATED;
    end else begin
      pre_verdict = V_ACCEPTED;
    end
  end

  // Lookup key, verdict and message id counter.
  verdict_t    verdict_r;
  logic [15:0] key_org_r, key_mid_r, next_id_r;
  logic [15:0] id_inc;

  assign id_inc = next_id_r + 16'd1;

  // Table walk: one read issued per cycle, the entry from the previous read checked.
  logic [DEDUP_ENTRIES-1:0] used_r;
  logic [CW-1:0]  ridx_r;
  logic [IW-1:0]  cidx_r, cursor_r;
  logic           pend_r, done_r, hit_r;
  logic [RAM_W-1:0] rdata;
  logic           chk_used, chk_expired, chk_match, hit_now, walk_end;

  assign chk_used    = pend_r && used_r[cidx_r];
  assign chk_expired = (now_r - rdata[31:0]) > window_r;
  assign chk_match   = (rdata[63:48] == key_org_r) && (rdata[47:32] == key_mid_r);
  assign hit_now     = chk_used && !chk_expired && chk_match;
  assign walk_end    = (ridx_r == CW'(DEDUP_ENTRIES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_id_r <= ID_RESET;
      used_r    <= '0;
      cursor_r  <= '0;
      done_r    <= 1'b0;
      hit_r     <= 1'b0;
      pend_r    <= 1'b0;
      ridx_r    <= '0;
    end else if (cmd.eval) begin
      verdict_r <= pre_verdict;
      ridx_r    <= '0;
      pend_r    <= 1'b0;
      done_r    <= 1'b0;
      hit_r     <= 1'b0;
      if (mode_r) begin
        key_org_r <= short_id;
        key_mid_r <= next_id_r;
        if (local_ok) begin
          next_id_r <= (id_inc == 16'd0) ? ID_RESET : id_inc;
        end
      end else begin
        key_org_r <= org_r;
        key_mid_r <= mid_r;
      end
    end else if (cmd.scan && !done_r) begin
      if (chk_used && chk_expired) begin
        used_r[cidx_r] <= 1'b0;
      end
      if (hit_now) begin
        hit_r  <= 1'b1;
        done_r <= 1'b1;
        pend_r <= 1'b0;
        if (!mode_r) begin
          verdict_r <= V_DUPLICATE;
        end
      end else if (!walk_end) begin
        cidx_r <= ridx_r[IW-1:0];
        ridx_r <= ridx_r + CW'(1);
        pend_r <= 1'b1;
      end else begin
        pend_r <= 1'b0;
        done_r <= !pend_r;
      end
    end else if (cmd.write) begin
      used_r[cursor_r] <= 1'b1;
      cursor_r <= (cursor_r == IW'(DEDUP_ENTRIES - 1)) ? '0 : cursor_r + IW'(1);
    end
  end

  mfdr_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEDUP_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (cursor_r),
    .wdata ({key_org_r, key_mid_r, now_r}),
    .raddr (ridx_r[IW-1:0]),
    .rdata (rdata)
  );

  assign sts.need_scan = (pre_verdict == V_ACCEPTED) || (pre_verdict == V_LOCAL_OK);
  assign sts.scan_done = done_r;
  assign sts.hit       = hit_r;

  // Result register.
  logic        deliver, forward;
  logic [7:0]  fwd_ttl, fwd_hops;
  logic [15:0] assigned_id;

  assign deliver     = (verdict_r == V_ACCEPTED);
  assign forward     = deliver && (ttl_r > 8'd1);
  assign fwd_ttl     = forward ? ttl_r - 8'd1 : 8'd0;
  assign fwd_hops    = forward ? hops_r + 8'd1 : 8'd0;
  assign assigned_id = (verdict_r == V_LOCAL_OK) ? key_mid_r : 16'd0;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tuser <= verdict_r;
      out_tdata <= {6'd0, assigned_id, fwd_hops, fwd_ttl, forward, deliver};
    end
  end

endmodule

// ===== sv/mesh_frame_dedup_relay.sv =====
// Top level of the mesh frame duplicate filter and relay block.
// Depends on mfdr_pkg, mfdr_ctrl, mfdr_dp and mfdr_ram.
//
//  channel   ports                             carries
//  input     in_tvalid/in_tready/tdata/tuser    one header or local send request
//  output    out_tvalid/out_tready/tdata/tuser  one verdict with relay fields
//  config    cfg_we/cfg_index/cfg_wdata         node id, duplicate window
//
// One item at a time. A rejected item goes from transfer to result with no table walk;
// an item that walks the table reads one entry per cycle through the single read port
// of the table memory, stops early on a hit and records the key on a miss. The next
// transfer can be taken in the cycle after the result is loaded. rst_n is synchronous:
// it empties the table and resets the id counter, configuration registers and controller.
// A new input is taken while an earlier result still waits at the output.
module mesh_frame_dedup_relay import mfdr_pkg::*; #(
  parameter int DEDUP_ENTRIES = DEDUP_ENTRIES_DEF,
  parameter int TEXT_MAX      = TEXT_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // frame_len[7:0], magic[15:8], version[23:16], frame_type[31:24],
  // origin[47:32], message_id[63:48], ttl[71:64], hops[79:72],
  // text_len[87:80], now_ms[119:88]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // mode[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // deliver[0], forward[1], fwd_ttl[9:2], fwd_hops[17:10], assigned_id[33:18]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // verdict[2:0]
  output logic [2:0]            out_tuser,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [31:0]           cfg_wdata
);

  mfdr_cmd_t cmd;
  mfdr_sts_t sts;

  mfdr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mfdr_dp #(
    .DEDUP_ENTRIES (DEDUP_ENTRIES),
    .TEXT_MAX      (TEXT_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for mesh_frame_dedup_relay: header checks, duplicate table
// with expiry, relay fields and local id assignment, predicted per transfer, checked in order.
// Depends on mfdr_pkg and the mesh_frame_dedup_relay RTL.
`timescale 1ns / 100ps

module tb;
  import mfdr_pkg::*;

  localparam int TABLE_SIZE = DEDUP_ENTRIES_DEF;
  localparam int TEXT_LIMIT = TEXT_MAX_DEF;
  localparam int SETTLE     = DEDUP_ENTRIES_DEF + 10;

  // Same layout as in_tdata: the last member sits in the lowest bits.
  typedef struct packed {
    logic [31:0] now_ms;
    logic [7:0]  text_len;
    logic [7:0]  hops;
    logic [7:0]  ttl;
    logic [15:0] message_id;
    logic [15:0] origin;
    logic [7:0]  frame_type;
    logic [7:0]  version;
    logic [7:0]  magic;
    logic [7:0]  frame_len;
  } relay_hdr_t;

  typedef struct packed {
    logic       mode;
    relay_hdr_t hdr;
  } relay_item_t;

  // Same layout as out_tdata.
  typedef struct packed {
    logic [5:0]  pad;
    logic [15:0] assigned_id;
    logic [7:0]  fwd_hops;
    logic [7:0]  fwd_ttl;
    logic        forward;
    logic        deliver;
  } relay_word_t;

  typedef struct {
    verdict_t    verdict;
    relay_word_t word;
  } relay_verdict_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;
  logic                  cfg_we     = 1'b0;
  cfg_idx_t              cfg_index  = CFG_NODE_ID;
  logic [31:0]           cfg_wdata  = '0;

  mesh_frame_dedup_relay dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Predictor state: registers and duplicate table as the block should hold them.
  logic [31:0] node_reg   = 32'd0;
  logic [31:0] window_reg = WINDOW_RESET;
  logic        tbl_used   [TABLE_SIZE];
  logic [15:0] tbl_origin [TABLE_SIZE];
  logic [15:0] tbl_msg    [TABLE_SIZE];
  logic [31:0] tbl_stamp  [TABLE_SIZE];
  int          repl_ptr   = 0;
  logic [15:0] id_next    = ID_RESET;

  relay_item_t    frame_q[$];
  relay_verdict_t verdict_q[$];
  logic [31:0]    recent_keys[$];
  relay_item_t    cur_item;
  relay_verdict_t want;
  relay_word_t    got_word;
  int             frames_queued = 0;
  int             frames_taken  = 0;
  int             mismatches    = 0;
  int             send_idle_pct = 0;
  int             stall_pct     = 0;
  logic [31:0]    now_clk       = 32'd0;

  function automatic logic [15:0] own_short_id();
    logic [15:0] s;
    s = node_reg[31:16] ^ node_reg[15:0];
    return (s == 16'd0) ? 16'd1 : s;
  endfunction

  // Expires stale entries up to the first live match; records the key on a miss.
  function automatic bit seen_or_insert(logic [15:0] org, logic [15:0] mid, logic [31:0] now);
    logic [31:0] age;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (!tbl_used[i])
        continue;
      age = now - tbl_stamp[i];
      if (age > window_reg) begin
        tbl_used[i] = 1'b0;
        continue;
      end
      if (tbl_origin[i] == org && tbl_msg[i] == mid)
        return 1'b1;
    end
    tbl_used[repl_ptr]   = 1'b1;
    tbl_origin[repl_ptr] = org;
    tbl_msg[repl_ptr]    = mid;
    tbl_stamp[repl_ptr]  = now;
    repl_ptr = (repl_ptr + 1) % TABLE_SIZE;
    return 1'b0;
  endfunction

  function automatic relay_verdict_t relay_decide(relay_item_t it);
    relay_verdict_t r;
    logic           text_bad;
    logic [15:0]    id;
    r.verdict = V_ACCEPTED;
    r.word    = '0;
    text_bad  = (it.hdr.text_len == 8'd0) || (int'(it.hdr.text_len) > TEXT_LIMIT);
    if (it.mode) begin
      if (it.hdr.ttl == 8'd0 || text_bad) begin
        r.verdict = V_LOCAL_REJ;
      end else begin
        id      = id_next;
        id_next = id_next + 16'd1;
        if (id_next == 16'd0)
          id_next = 16'd1;
        void'(seen_or_insert(own_short_id(), id, it.hdr.now_ms));
        r.verdict          = V_LOCAL_OK;
        r.word.assigned_id = id;
      end
    end else if (it.hdr.frame_len < HDR_BYTES) begin
      r.verdict = V_SHORT;
    end else if (it.hdr.magic != HDR_MAGIC || it.hdr.version != HDR_VERSION ||
                 it.hdr.frame_type != HDR_TYPE_TEXT) begin
      r.verdict = V_BAD_HDR;
    end else if (text_bad) begin
      r.verdict = V_BAD_TEXT;
    end else if (int'(it.hdr.frame_len) < int'(HDR_BYTES) + int'(it.hdr.text_len)) begin
      r.verdict = V_TRUNCATED;
    end else if (seen_or_insert(it.hdr.origin, it.hdr.message_id, it.hdr.now_ms)) begin
      r.verdict = V_DUPLICATE;
    end else begin
      r.word.deliver = 1'b1;
      if (it.hdr.ttl > 8'd1) begin
        r.word.forward  = 1'b1;
        r.word.fwd_ttl  = it.hdr.ttl - 8'd1;
        r.word.fwd_hops = it.hdr.hops + 8'd1;
      end
    end
    return r;
  endfunction

  function automatic relay_item_t hdr_item(logic [7:0] flen, logic [7:0] mag, logic [7:0] ver,
                                           logic [7:0] typ, logic [15:0] org, logic [15:0] mid,
                                           logic [7:0] ttl, logic [7:0] hops, logic [7:0] tlen,
                                           logic [31:0] now);
    relay_item_t it;
    it.mode = 1'b0;
    it.hdr  = '{now_ms: now, text_len: tlen, hops: hops, ttl: ttl, message_id: mid,
                origin: org, frame_type: typ, version: ver, magic: mag, frame_len: flen};
    return it;
  endfunction

  // Header fields other than ttl, text length and time mean nothing to a local send.
  function automatic relay_item_t local_item(logic [7:0] ttl, logic [7:0] tlen, logic [31:0] now);
    relay_item_t  it;
    logic [127:0] raw;
    raw             = {$urandom(), $urandom(), $urandom(), $urandom()};
    it.mode         = 1'b1;
    it.hdr          = raw[IN_DATA_W-1:0];
    it.hdr.ttl      = ttl;
    it.hdr.text_len = tlen;
    it.hdr.now_ms   = now;
    return it;
  endfunction

  task automatic enqueue(relay_item_t it);
    frame_q.push_back(it);
    frames_queued++;
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_NODE_ID)
      node_reg = val;
    else
      window_reg = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (frames_taken != frames_queued || verdict_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic advance_clock();
    case ($urandom_range(19))
      0:       now_clk += window_reg + 32'd1 + 32'($urandom_range(50));
      1:       now_clk += $urandom();
      default: now_clk += $urandom_range(0, (window_reg >> 4) + 3);
    endcase
  endtask

  // Mostly well-formed headers over a small key space so that duplicates and
  // expiry happen often; the rest is local sends, broken headers and noise.
  task automatic gen_random(int count);
    relay_item_t  it;
    logic [127:0] raw;
    logic [31:0]  key;
    logic [7:0]   tlen;
    int           pick;
    for (int n = 0; n < count; n++) begin
      advance_clock();
      pick = $urandom_range(99);
      if (pick < 15) begin
        it = local_item(($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
                        ($urandom_range(7) == 0) ? 8'($urandom_range(17, 255)) * 8'($urandom_range(1))
                                                 : 8'($urandom_range(1, TEXT_LIMIT)),
                        now_clk);
      end else if (pick < 25) begin
        raw     = {$urandom(), $urandom(), $urandom(), $urandom()};
        it.mode = 1'($urandom_range(1));
        it.hdr  = raw[IN_DATA_W-1:0];
      end else begin
        if (recent_keys.size() != 0 && $urandom_range(99) < 40) begin
          key = recent_keys[$urandom_range(recent_keys.size() - 1)];
        end else if ($urandom_range(9) == 0) begin
          key = {own_short_id(), id_next - 16'($urandom_range(1, 3))};
        end else begin
          key[31:16] = $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom());
          key[15:0]  = $urandom_range(1) ? 16'($urandom_range(15)) : 16'($urandom());
          recent_keys.push_back(key);
          if (recent_keys.size() > 24)
            void'(recent_keys.pop_front());
        end
        tlen = 8'($urandom_range(1, TEXT_LIMIT));
        it = hdr_item(8'(10 + int'(tlen) + $urandom_range(0, ($urandom_range(3) == 0) ? 245 - tlen : 4)),
                      HDR_MAGIC, HDR_VERSION, HDR_TYPE_TEXT, key[31:16], key[15:0],
                      8'($urandom()), 8'($urandom()), tlen, now_clk);
        if (pick < 37) begin
          case ($urandom_range(5))
            0: it.hdr.frame_len = 8'($urandom_range(0, 9));
            1: it.hdr.magic ^= 8'(1 << $urandom_range(7));
            2: it.hdr.version ^= 8'(1 << $urandom_range(7));
            3: it.hdr.frame_type ^= 8'(1 << $urandom_range(7));
            4: it.hdr.text_len = $urandom_range(1) ? 8'd0 : 8'($urandom_range(17, 255));
            default: it.hdr.frame_len = 8'($urandom_range(10, 9 + int'(tlen)));
          endcase
        end
      end
      enqueue(it);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Driver: offers the next pending frame and predicts each one on transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        verdict_q.push_back(relay_decide(cur_item));
        frames_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (frame_q.size() != 0 &&
            (send_idle_pct == 0 || $urandom_range(99) >= send_idle_pct)) begin
          cur_item  = frame_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= cur_item.hdr;
          in_tuser  <= cur_item.mode;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_word = out_tdata;
      if (verdict_q.size() == 0) begin
        $error("result transfer with nothing expected: verdict %0d", out_tuser);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        check_field("verdict", want.verdict, out_tuser);
        check_field("deliver", want.word.deliver, got_word.deliver);
        check_field("forward", want.word.forward, got_word.forward);
        check_field("fwd_ttl", want.word.fwd_ttl, got_word.fwd_ttl);
        check_field("fwd_hops", want.word.fwd_hops, got_word.fwd_hops);
        check_field("assigned_id", want.word.assigned_id, got_word.assigned_id);
        check_field("tdata padding", 32'd0, got_word.pad);
      end
    end
    out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  initial begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      tbl_used[i]   = 1'b0;
      tbl_origin[i] = '0;
      tbl_msg[i]    = '0;
      tbl_stamp[i]  = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings: node id 0 gives short id 1.
    enqueue(local_item(8'd3, 8'd5, 32'd100));
    enqueue(hdr_item(8'd20, HDR_MAGIC, HDR_VERSION, HDR_TYPE_TEXT, 16'd1, 16'd1,
                     8'd4, 8'd0, 8'd5, 32'd200));
    enqueue(local_item(8'd0, 8'd5, 32'd210));
    enqueue(local_item(8'd3, 8'd0, 32'd220));
    enqueue(local_item(8'd3, 8'd17, 32'd230));
    enqueue(local_item(8'd255, 8'd16, 32'd300));
    enqueue(hdr_item(8'd0, HDR_MAGIC, HDR_VERSION, HDR_TYPE_TEXT, 16'd9, 16'd9,
                     8'd3, 8'd0, 8'd1, 32'd310));
    enqueue(hdr_item(8'd9, HDR_MAGIC, HDR_VERSION, HDR_TYPE_TEXT, 16'd9, 16'd9,
                     8'd3, 8'd0, 8'd1, 32'd310));
    enqueue(hdr_item(8'd20, 8'h00, HDR_VERSION, HDR_TYPE_TEXT, 16'd9, 16'd9,
                     8'd3, 8'd0, 8'd5, 32'd310));
    enqueue(hdr_item(8'd20, HDR_MAGIC, 8'd2, HDR_TYPE_TEXT, 16'd9, 16'd9,
                     8'd3, 8'd0, 8'd5, 32'd310));
    enqueue(hdr_item(8'd20, HDR_MAGIC, HDR_VERSION, 8'd0, 16'd9, 16'd9,
                     8'd3, 8'd0, 8'd5, 32'd310));
    enqueue(hdr_item(8'd255, 8'hFF, 8'hFF, 8'hFF, 16'd9, 16'd9,
                     8'd3, 8'd0, 8'd5, 32'd310));
    enqueue(hdr_item(8'd20, HDR_MAGIC, HDR_VERSION, HDR_TYPE_TEXT, 16'd9, 16'd9,
                     8'd3, 8'd0, 8'd0, 32'd310));
    enqueue(hdr_item(8'd255, HDR_MAGIC, HDR_VERSION, HDR_TYPE_TEXT, 16'd9, 16'd9,
                     8'd3, 8'd0, 8'd17, 32'd310));
    enqueue(hdr_item(8'd255, HDR_MAGIC, HDR_VERSION, HDR_TYPE_TEXT, 16'd9, 16'd9,
                     8'd3, 8'd0, 8'd255, 32'd310));
    enqueue(hdr_item(8'd25, HDR_MAGIC, HDR_VERSION, HDR_TYPE_TEXT, 16'd9, 16'd9,
                     8'd3, 8'd0, 8'd16, 32'd310));
    // Highest ttl and hops: hops wraps to zero on relay.
    enqueue(hdr_item(8'd26, HDR_MAGIC, HDR_VERSION, HDR_TYPE_TEXT, 16'hFFFF, 16'hFFFF,
                     8'd255, 8'd255, 8'd16, 32'd400));
    // Age equal to the window is still live; one more millisecond expires it.
    enqueue(hdr_item(8'd26, HDR_MAGIC, HDR_VERSION, HDR_TYPE_TEXT, 16'hFFFF, 16'hFFFF,
                     8'd255, 8'd255, 8'd16, 32'd30400));
    enqueue(hdr_item(8'd26, HDR_MAGIC, HDR_VERSION, HDR_TYPE_TEXT, 16'hFFFF, 16'hFFFF,
                     8'd255, 8'd255, 8'd16, 32'd30401));
    enqueue(hdr_item(8'd255, HDR_MAGIC, HDR_VERSION, HDR_TYPE_TEXT, 16'd0, 16'd0,
                     8'd1, 8'd7, 8'd1, 32'd30402));
    enqueue(hdr_item(8'd255, HDR_MAGIC, HDR_VERSION, HDR_TYPE_TEXT, 16'd0, 16'd1,
                     8'd0, 8'd7, 8'd1, 32'd30403));
    // Time wraps between these two, so the second one is still a duplicate.
    enqueue(hdr_item(8'd11, HDR_MAGIC, HDR_VERSION, HDR_TYPE_TEXT, 16'd5, 16'd5,
                     8'd2, 8'd7, 8'd1, 32'hFFFF_FFF0));
    enqueue(hdr_item(8'd11, HDR_MAGIC, HDR_VERSION, HDR_TYPE_TEXT, 16'd5, 16'd5,
                     8'd2, 8'd7, 8'd1, 32'h0000_0010));
    now_clk = 32'h0000_0020;
    gen_random(80);
    wait_drained();

    set_reg(CFG_NODE_ID, 32'hFFFF_FFFF);
    set_reg(CFG_WINDOW, 32'd0);
    send_idle_pct = 70;
    gen_random(90);
    wait_drained();

    set_reg(CFG_NODE_ID, 32'h1234_5678);
    set_reg(CFG_WINDOW, 32'hFFFF_FFFF);
    send_idle_pct = 0;
    stall_pct     = 70;
    gen_random(90);
    wait_drained();

    set_reg(CFG_NODE_ID, $urandom());
    set_reg(CFG_WINDOW, 32'd1000);
    send_idle_pct = 8;
    stall_pct     = 8;
    gen_random(90);
    wait_drained();

    set_reg(CFG_NODE_ID, 32'h0001_0001);
    set_reg(CFG_WINDOW, WINDOW_RESET);
    send_idle_pct = 0;
    stall_pct     = 0;
    gen_random(90);
    wait_drained();

    gen_random(60);
    wait_drained();

    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
